/* hw/rtl/rcm_pkg.sv */
// ----------------------------------------------------------------------------
// rcm_pkg
// shared constants for the roi row / column mean core
// ----------------------------------------------------------------------------
package rcm_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   localparam int PIXEL_W     = 32;
   localparam int CFG_W       = 11;
   localparam int CSR_IDX_W   = 3;
   localparam int POS_W       = 10;
   localparam int KIND_W      = 2;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 48;

   // request kinds
   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_ROW    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FRAME  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_COLUMN = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_RASTER_COLS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RASTER_ROWS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROI_LEFT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ROI_RIGHT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ROI_TOP     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ROI_BOTTOM  = 3'd5;

   // register reset values
   localparam logic [CFG_W-1:0] RST_RASTER_COLS = 11'd640;
   localparam logic [CFG_W-1:0] RST_RASTER_ROWS = 11'd480;
   localparam logic [CFG_W-1:0] RST_ROI_LEFT    = 11'd0;
   localparam logic [CFG_W-1:0] RST_ROI_RIGHT   = 11'd640;
   localparam logic [CFG_W-1:0] RST_ROI_TOP     = 11'd0;
   localparam logic [CFG_W-1:0] RST_ROI_BOTTOM  = 11'd480;

endpackage

/* hw/rtl/roi_row_column_mean_core.sv */
// ----------------------------------------------------------------------------
// roi_row_column_mean_core
// row, column and frame means of a q16.16 raster stream inside a roi
// ----------------------------------------------------------------------------
// Pixels arrive in raster order as requests of kind pixel; a request of kind
// read returns the mean of one column sum. Column sums live in one ram of
// MAX_WIDTH entries, updated by read-modify-write, so a pixel that does not
// close a row holds the core for a ram read and a write-back. A row end runs
// a shared restoring divider, one quotient bit per cycle over the full frame
// sum width (52 bits at the defaults); a frame end adds a second division
// for the frame mean. A column read also runs the divider. A zero divisor
// skips the divider. A result that cannot leave holds the core in its
// output step. The result sits in an output register, so a new request is
// taken while an earlier result still waits. Column sums are undefined
// until the first row of a frame writes them; no clearing pass is run.
// ----------------------------------------------------------------------------
module roi_row_column_mean_core
   import rcm_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // pixel_value, read_column
   input  logic                   req_tuser,  // req_type
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // position, mean_value, zero_divisor
   output logic [KIND_W-1:0]      rsp_tuser,  // result_kind
   output logic                   rsp_tlast,
   // register writes
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);

   localparam int CW    = $clog2(MAX_WIDTH);       // column index
   localparam int RW    = $clog2(MAX_HEIGHT);      // row index
   localparam int WW    = $clog2(MAX_WIDTH + 1);   // clamped width
   localparam int HW    = $clog2(MAX_HEIGHT + 1);  // clamped height
   localparam int RS_W  = PIXEL_W + CW;            // row sum
   localparam int CS_W  = PIXEL_W + RW;            // column sum
   localparam int NUM_W = PIXEL_W + CW + RW;       // frame sum, divider numerator
   localparam int DEN_W = (CFG_W > WW + HW) ? CFG_W : WW + HW;
   localparam int CNT_W = $clog2(NUM_W + 1);
   localparam int PAD_W = RSP_TDATA_W - (POS_W + PIXEL_W + 1);

   // state codes
   localparam logic [2:0] S_IDLE  = 3'd0;  // wait for a request
   localparam logic [2:0] S_RMW   = 3'd1;  // column sum back from ram, write it
   localparam logic [2:0] S_COLRD = 3'd2;  // column sum back from ram for a read
   localparam logic [2:0] S_DIV   = 3'd3;  // divider running
   localparam logic [2:0] S_OUT   = 3'd4;  // result into output register

   logic [2:0] state_ff, state_in;

   // configuration
   logic [CFG_W-1:0] raster_cols_ff, raster_rows_ff;
   logic [CFG_W-1:0] roi_left_ff, roi_right_ff, roi_top_ff, roi_bottom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         raster_cols_ff <= RST_RASTER_COLS;
         raster_rows_ff <= RST_RASTER_ROWS;
         roi_left_ff    <= RST_ROI_LEFT;
         roi_right_ff   <= RST_ROI_RIGHT;
         roi_top_ff     <= RST_ROI_TOP;
         roi_bottom_ff  <= RST_ROI_BOTTOM;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_RASTER_COLS: raster_cols_ff <= csr_wdata;
            REG_RASTER_ROWS: raster_rows_ff <= csr_wdata;
            REG_ROI_LEFT:    roi_left_ff    <= csr_wdata;
            REG_ROI_RIGHT:   roi_right_ff   <= csr_wdata;
            REG_ROI_TOP:     roi_top_ff     <= csr_wdata;
            REG_ROI_BOTTOM:  roi_bottom_ff  <= csr_wdata;
            default: ;  // unused indexes are ignored
         endcase
      end
   end

   // request fields
   logic                      req_type;
   logic signed [PIXEL_W-1:0] pixel_value;
   logic [POS_W-1:0]          read_column;
   logic                      req_fire;

   assign req_type    = req_tuser;
   assign pixel_value = req_tdata[PIXEL_W-1:0];
   assign read_column = req_tdata[PIXEL_W+POS_W-1:PIXEL_W];
   assign req_tready  = (state_ff == S_IDLE);
   assign req_fire    = req_tvalid && req_tready;

   // clamped frame size and raster position
   logic [WW-1:0] w_eff;
   logic [HW-1:0] h_eff;
   logic [CW-1:0] col_count_ff, c_sel;
   logic [RW-1:0] row_count_ff, r_sel;
   logic          in_cols, in_rows, row_end, frame_end;
   logic [WW+HW-1:0] frame_den_ff;

   always_comb begin
      if (raster_cols_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(raster_cols_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(raster_cols_ff);
      end
      if (raster_rows_ff == '0) begin
         h_eff = HW'(1);
      end else if (32'(raster_rows_ff) > 32'(MAX_HEIGHT)) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(raster_rows_ff);
      end
      c_sel     = (WW'(col_count_ff) >= w_eff) ? CW'(w_eff - WW'(1)) : col_count_ff;
      r_sel     = (HW'(row_count_ff) >= h_eff) ? RW'(h_eff - HW'(1)) : row_count_ff;
      in_cols   = (32'(c_sel) > 32'(roi_left_ff)) && (32'(c_sel) < 32'(roi_right_ff));
      in_rows   = (32'(r_sel) > 32'(roi_top_ff)) && (32'(r_sel) < 32'(roi_bottom_ff));
      row_end   = (WW'(c_sel) == w_eff - WW'(1));
      frame_end = (HW'(r_sel) == h_eff - HW'(1));
   end

   // frame divisor, registered after the multiply
   always_ff @(posedge clock) begin
      frame_den_ff <= (WW + HW)'(w_eff) * (WW + HW)'(h_eff);
   end

   // signed roi spans
   logic signed [CFG_W:0] roi_w_span, roi_h_span;
   assign roi_w_span = $signed({1'b0, roi_right_ff}) - $signed({1'b0, roi_left_ff});
   assign roi_h_span = $signed({1'b0, roi_bottom_ff}) - $signed({1'b0, roi_top_ff});

   // column sum ram
   logic                   mem_we;
   logic [CW-1:0]          mem_raddr;
   logic signed [CS_W-1:0] mem_wdata, mem_rdata;

   // request held during its work
   logic signed [PIXEL_W-1:0] px_ff;
   logic [CW-1:0]             c_ff;
   logic [RW-1:0]             r_ff;
   logic                      in_rows_ff, row_end_ff, frame_end_ff;
   logic [POS_W-1:0]          read_col_ff;
   logic                      col_ok_ff;

   // running sums
   logic signed [RS_W-1:0]  row_sum_ff;
   logic signed [NUM_W-1:0] frame_sum_ff;

   assign mem_raddr = (req_type == REQ_READ) ? CW'(read_column) : c_sel;

   // first row of a frame overwrites, later rows inside the roi accumulate
   always_comb begin
      if (r_ff == '0) begin
         mem_wdata = in_rows_ff ? CS_W'(px_ff) : '0;
      end else begin
         mem_wdata = mem_rdata + CS_W'(px_ff);
      end
   end
   assign mem_we = (state_ff == S_RMW) && ((r_ff == '0) || in_rows_ff);

   rcm_ram #(
      .WIDTH (CS_W),
      .DEPTH (MAX_WIDTH)
   ) u_col_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (c_ff),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // output register
   logic                      rsp_valid_ff;
   logic [KIND_W-1:0]         rsp_kind_ff;
   logic [POS_W-1:0]          rsp_pos_ff;
   logic signed [PIXEL_W-1:0] rsp_mean_ff;
   logic                      rsp_zd_ff, rsp_last_ff;
   logic                      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // job selection for the divider
   logic                     pending_frame_ff;
   logic                     job_start;
   logic signed [NUM_W-1:0]  job_num;
   logic signed [DEN_W:0]    job_den;
   logic [KIND_W-1:0]        job_kind;
   logic [POS_W-1:0]         job_pos;
   logic                     job_last;

   always_comb begin
      job_start = 1'b0;
      job_num   = '0;
      job_den   = (DEN_W + 1)'(1);
      job_kind  = KIND_ROW;
      job_pos   = '0;
      job_last  = 1'b1;
      if ((state_ff == S_RMW) && row_end_ff) begin
         job_start = 1'b1;
         job_num   = NUM_W'(row_sum_ff);
         job_den   = (DEN_W + 1)'(roi_w_span);
         job_pos   = POS_W'(r_ff);
         job_last  = !frame_end_ff;
      end else if (state_ff == S_COLRD) begin
         job_start = 1'b1;
         job_kind  = KIND_COLUMN;
         job_pos   = read_col_ff;
         if (col_ok_ff) begin
            job_num = NUM_W'(mem_rdata);
            job_den = (DEN_W + 1)'(roi_h_span);
         end
      end else if ((state_ff == S_OUT) && out_free && pending_frame_ff) begin
         job_start = 1'b1;
         job_kind  = KIND_FRAME;
         job_num   = frame_sum_ff;
         job_den   = (DEN_W + 1)'($signed({1'b0, frame_den_ff}));
      end
   end

   // restoring divider on magnitudes
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W:0]   rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] div_cnt_ff;
   logic             neg_ff, zd_ff;
   logic [KIND_W-1:0] kind_ff;
   logic [POS_W-1:0]  pos_ff;
   logic              last_ff;
   logic [DEN_W:0]    trial;
   logic              trial_ok;
   logic signed [PIXEL_W-1:0] mean_sat;

   assign trial    = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
   assign trial_ok = (trial >= {1'b0, den_ff});

   // truncated quotient saturated to 32 bits
   always_comb begin
      if (neg_ff) begin
         if (quo_ff > NUM_W'(64'h8000_0000)) begin
            mean_sat = 32'sh8000_0000;
         end else begin
            mean_sat = PIXEL_W'(-quo_ff);
         end
      end else begin
         if (quo_ff > NUM_W'(64'h7FFF_FFFF)) begin
            mean_sat = 32'sh7FFF_FFFF;
         end else begin
            mean_sat = PIXEL_W'(quo_ff);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = (req_type == REQ_READ) ? S_COLRD : S_RMW;
            end
         end
         S_RMW: begin
            if (row_end_ff) begin
               state_in = (job_den == '0) ? S_OUT : S_DIV;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_COLRD: state_in = (job_den == '0) ? S_OUT : S_DIV;
         S_DIV: begin
            if (div_cnt_ff == CNT_W'(1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               state_in = pending_frame_ff ? S_DIV : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         col_count_ff     <= '0;
         row_count_ff     <= '0;
         row_sum_ff       <= '0;
         frame_sum_ff     <= '0;
         pending_frame_ff <= 1'b0;
         div_cnt_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;

         // pixel request: raster position and sums
         if (req_fire && (req_type == REQ_PIXEL)) begin
            row_sum_ff   <= row_sum_ff + (in_cols ? RS_W'(pixel_value) : '0);
            frame_sum_ff <= frame_sum_ff + NUM_W'(pixel_value);
            if (row_end) begin
               col_count_ff <= '0;
               row_count_ff <= frame_end ? '0 : r_sel + RW'(1);
            end else begin
               col_count_ff <= c_sel + CW'(1);
               row_count_ff <= r_sel;
            end
         end

         // row mean leaves the row sum, frame mean leaves the frame sum
         if ((state_ff == S_RMW) && row_end_ff) begin
            row_sum_ff       <= '0;
            pending_frame_ff <= frame_end_ff;
         end
         if ((state_ff == S_OUT) && out_free && pending_frame_ff) begin
            frame_sum_ff     <= '0;
            pending_frame_ff <= 1'b0;
         end

         // divider count
         if (job_start) begin
            div_cnt_ff <= (job_den == '0) ? '0 : CNT_W'(NUM_W);
         end else if (state_ff == S_DIV) begin
            div_cnt_ff <= div_cnt_ff - CNT_W'(1);
         end

         // output register
         if (state_ff == S_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         px_ff       <= pixel_value;
         c_ff        <= c_sel;
         r_ff        <= r_sel;
         in_rows_ff  <= in_rows;
         row_end_ff  <= row_end;
         frame_end_ff <= frame_end;
         read_col_ff <= read_column;
         col_ok_ff   <= (32'(read_column) < 32'(MAX_WIDTH));
      end

      if (job_start) begin
         kind_ff <= job_kind;
         pos_ff  <= job_pos;
         last_ff <= job_last;
         rem_ff  <= '0;
         if (job_den == '0) begin
            zd_ff  <= 1'b1;
            neg_ff <= 1'b0;
            quo_ff <= '0;
         end else begin
            zd_ff  <= 1'b0;
            neg_ff <= job_num[NUM_W-1] ^ job_den[DEN_W];
            quo_ff <= job_num[NUM_W-1] ? NUM_W'(-job_num) : NUM_W'(job_num);
            den_ff <= job_den[DEN_W] ? DEN_W'(-job_den) : DEN_W'(job_den);
         end
      end else if (state_ff == S_DIV) begin
         rem_ff <= trial_ok ? trial - {1'b0, den_ff} : trial;
         quo_ff <= {quo_ff[NUM_W-2:0], trial_ok};
      end

      if (state_ff == S_OUT && out_free) begin
         rsp_kind_ff <= kind_ff;
         rsp_pos_ff  <= pos_ff;
         rsp_mean_ff <= mean_sat;
         rsp_zd_ff   <= zd_ff;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {PAD_W'(0), rsp_zd_ff, rsp_mean_ff, rsp_pos_ff};

   // a forced zero divisor always shows a zero mean
   a_zd_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_zd_ff |-> rsp_mean_ff == '0)
      else $error("zero divisor result with nonzero mean");

   // frame mean is the closing result at position zero
   a_frame_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff == KIND_FRAME) |-> rsp_last_ff && (rsp_pos_ff == '0))
      else $error("frame mean without last or with a position");

   // divider counts only while dividing
   a_div_cnt : assert property (@(posedge clock) disable iff (reset)
      (div_cnt_ff != '0) |-> (state_ff == S_DIV))
      else $error("divider count outside division");

   // an accepted pixel goes to the ram write-back next
   a_pixel_rmw : assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_type == REQ_PIXEL) |=> (state_ff == S_RMW))
      else $error("pixel request skipped write-back");

   // a row end row sum is cleared once its mean is started
   a_row_clear : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RMW) && row_end_ff |=> (row_sum_ff == '0))
      else $error("row sum not cleared at row end");

endmodule

/* hw/rtl/rcm_ram.sv */
// ----------------------------------------------------------------------------
// rcm_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* sim/roi_row_column_mean_core_test.sv */
// ----------------------------------------------------------------------------
// roi_row_column_mean_core_test
// self-checking bench for the roi row / column / frame mean core
// ----------------------------------------------------------------------------
// A model of the core's state predicts every result of each accepted
// request. Results are checked in order, field by field. The bench runs
// zero-size frames that hit the size clamp, a short directed frame, random
// register settings with random frames and column reads, and a long
// receiver stall that fills the core.
// ----------------------------------------------------------------------------
module roi_row_column_mean_core_test;
   import rcm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAXW        = DEF_MAX_WIDTH;
   localparam int MAXH        = DEF_MAX_HEIGHT;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [POS_W-1:0]   pos;
      logic [PIXEL_W-1:0] mean;
      logic               zdiv;
      logic               last;
   } mean_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;  // pixel_value, read_column
   logic                   req_tuser = REQ_PIXEL;  // req_type
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;  // position, mean_value, zero_divisor
   logic [KIND_W-1:0]      rsp_tuser;  // result_kind
   logic                   rsp_tlast;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = REG_RASTER_COLS;
   logic [CFG_W-1:0]       csr_wdata = '0;

   // shadow of the core state
   int unsigned   raster_cols, raster_rows, roi_left, roi_right, roi_top, roi_bottom;
   longint        col_sum [MAXW];
   bit            col_valid [MAXW];
   int unsigned   valid_cols [$];
   longint        row_acc, frame_acc;
   int unsigned   cur_row, cur_col;

   mean_result_type pending_means [$];
   int            error_count = 0;
   int            requests_sent = 0;
   longint        cycle_count = 0;
   bit            quiet = 1'b0;       // no idling in the last stretch
   bit            long_hold_req = 1'b0;
   int            stall_left = 0;

   roi_row_column_mean_core u_top (.*);

   always #10 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("roi_row_column_mean_core_test: errors");
         $finish;
      end
   end

   // receiver: random stall bursts, plus one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (long_hold_req) begin
         long_hold_req = 1'b0;
         stall_left = 600;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // result checker
   always @(posedge clock) begin
      mean_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_means.size() == 0) begin
            $error("unexpected result kind %0d data %h", rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            exp_r = pending_means.pop_front();
            if (rsp_tuser !== exp_r.kind) begin
               $error("result_kind exp %0d got %0d", exp_r.kind, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[9:0] !== exp_r.pos) begin
               $error("position exp %0d got %0d", exp_r.pos, rsp_tdata[9:0]);
               error_count++;
            end
            if (rsp_tdata[41:10] !== exp_r.mean) begin
               $error("mean_value exp %h got %h", exp_r.mean, rsp_tdata[41:10]);
               error_count++;
            end
            if (rsp_tdata[42] !== exp_r.zdiv) begin
               $error("zero_divisor exp %0d got %0d", exp_r.zdiv, rsp_tdata[42]);
               error_count++;
            end
            if (rsp_tlast !== exp_r.last) begin
               $error("last exp %0d got %0d", exp_r.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // quotient truncated toward zero, saturated to 32 bits
   function automatic void push_mean(logic [KIND_W-1:0] kind, int unsigned pos,
                                     longint num, longint den, bit last);
      mean_result_type r;
      longint q;
      q = 0;
      r.zdiv = (den == 0);
      if (den != 0) begin
         q = num / den;
         if (q > 64'sd2147483647) q = 64'sd2147483647;
         if (q < -64'sd2147483648) q = -64'sd2147483648;
      end
      r.kind = kind;
      r.pos  = pos[POS_W-1:0];
      r.mean = q[31:0];
      r.last = last;
      pending_means.push_back(r);
   endfunction

   function automatic int unsigned clamp_size(int unsigned v, int unsigned maxv);
      if (v < 1) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic void predict_read(int unsigned col);
      push_mean(KIND_COLUMN, col, col_valid[col] ? col_sum[col] : 0,
                longint'(roi_bottom) - longint'(roi_top), 1'b1);
   endfunction

   function automatic void predict_pixel(logic signed [31:0] px);
      int unsigned w, h, c, r;
      bit in_rows, frame_end;
      w = clamp_size(raster_cols, MAXW);
      h = clamp_size(raster_rows, MAXH);
      c = (cur_col >= w) ? w - 1 : cur_col;
      r = (cur_row >= h) ? h - 1 : cur_row;
      if (c > roi_left && c < roi_right) row_acc += px;
      in_rows = (r > roi_top && r < roi_bottom);
      // first row of a frame overwrites the column sum
      if (r == 0) begin
         col_sum[c] = in_rows ? longint'(px) : 0;
         if (!col_valid[c]) valid_cols.push_back(c);
         col_valid[c] = 1'b1;
      end else if (in_rows) begin
         col_sum[c] += px;
      end
      frame_acc += px;
      if (c + 1 < w) begin
         cur_col = c + 1;
         cur_row = r;
         return;
      end
      frame_end = (r + 1 >= h);
      push_mean(KIND_ROW, r, row_acc, longint'(roi_right) - longint'(roi_left), !frame_end);
      row_acc = 0;
      cur_col = 0;
      if (!frame_end) begin
         cur_row = r + 1;
         return;
      end
      push_mean(KIND_FRAME, 0, frame_acc, longint'(w) * longint'(h), 1'b1);
      frame_acc = 0;
      cur_row = 0;
   endfunction

   // one request, with an optional idle gap first
   task automatic send_request(logic kind, logic [31:0] px, logic [9:0] col);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'd0, col, px};
      do @(posedge clock); while (!req_tready);
      if (kind == REQ_READ) predict_read(col);
      else predict_pixel(px);
      requests_sent++;
   endtask

   task automatic send_pixel(logic [31:0] px);
      send_request(REQ_PIXEL, px, 10'($urandom));
   endtask

   // reads only go to columns that have been written
   task automatic send_read();
      if (valid_cols.size() > 0)
         send_request(REQ_READ, $urandom,
                      10'(valid_cols[$urandom_range(0, valid_cols.size() - 1)]));
   endtask

   function automatic logic [31:0] pick_pixel();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // drain, let the core settle, then write
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned value);
      req_tvalid <= 1'b0;
      while (pending_means.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CFG_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_RASTER_COLS: raster_cols = value & 11'h7ff;
         REG_RASTER_ROWS: raster_rows = value & 11'h7ff;
         REG_ROI_LEFT:    roi_left    = value & 11'h7ff;
         REG_ROI_RIGHT:   roi_right   = value & 11'h7ff;
         REG_ROI_TOP:     roi_top     = value & 11'h7ff;
         default:         roi_bottom  = value & 11'h7ff;
      endcase
   endtask

   task automatic set_geometry(int unsigned w, int unsigned h, int unsigned l,
                               int unsigned r, int unsigned t, int unsigned b);
      write_reg(REG_RASTER_COLS, w);
      write_reg(REG_RASTER_ROWS, h);
      write_reg(REG_ROI_LEFT, l);
      write_reg(REG_ROI_RIGHT, r);
      write_reg(REG_ROI_TOP, t);
      write_reg(REG_ROI_BOTTOM, b);
   endtask

   // zero width and height clamp to a single pixel frame
   task automatic test_size_clamp();
      set_geometry(0, 0, 0, 1024, 0, 1024);
      for (int i = 0; i < 6; i++) send_pixel(pick_pixel());
      send_request(REQ_READ, 32'hffff_ffff, 10'd0);
   endtask

   // small frame with extreme pixels, column reads inside and after the frame, and a zero divisor
   task automatic test_directed_frame();
      set_geometry(4, 3, 0, 3, 0, 2);
      send_pixel(32'h7fff_ffff);
      send_pixel(32'h7fff_ffff);
      send_pixel(32'h8000_0000);
      send_pixel(32'h0000_0001);
      send_pixel(32'h8000_0000);
      send_read();
      send_pixel(32'hffff_ffff);
      send_pixel(32'h0001_0000);
      send_pixel(32'h7fff_ffff);
      for (int i = 0; i < 4; i++) send_pixel(pick_pixel());
      send_request(REQ_READ, 32'h0, 10'd1);
      // equal left and right edges: zero divisor on rows; inverted top and bottom too
      set_geometry(2, 2, 1, 1, 5, 2);
      for (int i = 0; i < 4; i++) send_pixel(pick_pixel());
      send_read();
   endtask

   // receiver holds off a long time while rows keep arriving
   task automatic test_backpressure();
      set_geometry(2, 3, 0, 2, 0, 3);
      long_hold_req = 1'b1;
      for (int i = 0; i < 24; i++) send_pixel(pick_pixel());
   endtask

   task automatic test_random_frames();
      int unsigned w, h;
      while (requests_sent < 800) begin
         w = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 8);
         h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 5);
         set_geometry(w, h,
                      ($urandom_range(0, 19) == 0) ? 1024 : $urandom_range(0, w + 1),
                      ($urandom_range(0, 19) == 0) ? 1024 : $urandom_range(0, w + 1),
                      ($urandom_range(0, 19) == 0) ? 1024 : $urandom_range(0, h + 1),
                      ($urandom_range(0, 19) == 0) ? 1024 : $urandom_range(0, h + 1));
         repeat ($urandom_range(20, 60)) begin
            if (requests_sent > 700) quiet = 1'b1;
            if ($urandom_range(0, 9) == 0) send_read();
            else send_pixel(pick_pixel());
         end
      end
   endtask

   initial begin
      raster_cols = RST_RASTER_COLS;
      raster_rows = RST_RASTER_ROWS;
      roi_left    = RST_ROI_LEFT;
      roi_right   = RST_ROI_RIGHT;
      roi_top     = RST_ROI_TOP;
      roi_bottom  = RST_ROI_BOTTOM;
      row_acc = 0;
      frame_acc = 0;
      cur_row = 0;
      cur_col = 0;
      foreach (col_valid[i]) col_valid[i] = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_size_clamp();
      test_directed_frame();
      test_backpressure();
      test_random_frames();

      req_tvalid <= 1'b0;
      while (pending_means.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0 && pending_means.size() == 0) begin
         $display("roi_row_column_mean_core_test: clean");
      end else begin
         $display("roi_row_column_mean_core_test: errors");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/rcm_pkg.sv
hw/rtl/rcm_ram.sv
hw/rtl/roi_row_column_mean_core.sv
sim/roi_row_column_mean_core_test.sv
